// ===== rtl/core/afe_pkg.sv =====
// Shared types and constants for the audio fade envelope unit.
// Used by afe_ctrl, afe_datapath and audio_fade_envelope_unit; depends on nothing.
package afe_pkg;

  localparam int unsigned SMP_W  = 16;              // audio sample width
  localparam int unsigned LEN_W  = 18;              // fade length register width
  localparam int unsigned CNT_W  = 19;              // signed fade counter width
  localparam int unsigned MAG_W  = LEN_W;           // gain magnitude width
  localparam int unsigned ABS_W  = SMP_W + 1;       // sample magnitude width
  localparam int unsigned PROD_W = ABS_W + MAG_W;   // product width
  localparam int unsigned QUO_W  = 17;              // quotient bits developed
  localparam int unsigned STEP_W = $clog2(QUO_W);

  localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(66150);
  localparam logic [QUO_W-1:0] SAT_POS_MAG = QUO_W'(32767);
  localparam logic [QUO_W-1:0] SAT_NEG_MAG = QUO_W'(32768);
  localparam logic [SMP_W-1:0] SAT_POS     = 16'h7FFF;
  localparam logic [SMP_W-1:0] SAT_NEG     = 16'h8000;

  typedef enum logic [1:0] {
    REQ_SAMPLE    = 2'd0,
    REQ_START     = 2'd1,
    REQ_FADE_DOWN = 2'd2,
    REQ_STOP      = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INIT,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [SMP_W-1:0] sample_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    fade_done;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic mul_en;
    logic div_init;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
    logic div_last;
  } dp_status_t;

endpackage

// ===== rtl/core/afe_ctrl.sv =====
// Sequencer for the audio fade envelope unit: handshakes and datapath commands.
// Depends on afe_pkg.
module afe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  afe_pkg::dp_status_t status_i,
  output afe_pkg::ctrl_cmd_t  cmd_o
);

  afe_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afe_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.has_result) state_d = afe_pkg::ST_MUL;
      end
      afe_pkg::ST_MUL:  state_d = afe_pkg::ST_INIT;
      afe_pkg::ST_INIT: state_d = afe_pkg::ST_DIV;
      afe_pkg::ST_DIV: begin
        if (status_i.div_last) state_d = afe_pkg::ST_FIN;
      end
      afe_pkg::ST_FIN: begin
        if (out_free) state_d = afe_pkg::ST_IDLE;
      end
      default: state_d = afe_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      afe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      afe_pkg::ST_MUL:  cmd_o.mul_en   = 1'b1;
      afe_pkg::ST_INIT: cmd_o.div_init = 1'b1;
      afe_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      afe_pkg::ST_FIN:  cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cmd_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take && !status_i.has_result |=> state_q == afe_pkg::ST_IDLE)
    else $error("command word left the idle state");

  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == afe_pkg::ST_DIV && status_i.div_last |=> state_q == afe_pkg::ST_FIN)
    else $error("divider finished but result not formed");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !out_valid_q || out_ready_i)
    else $error("output register overwritten while held");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

// ===== rtl/core/afe_datapath.sv =====
// Datapath of the audio fade envelope unit: fade counter, multiplier,
// restoring divider and output register. Depends on afe_pkg.
module afe_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [afe_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  afe_pkg::in_word_t          in_word_i,
  input  afe_pkg::ctrl_cmd_t         cmd_i,
  output afe_pkg::dp_status_t        status_o,
  output afe_pkg::out_word_t         out_word_o
);

  logic [afe_pkg::LEN_W-1:0]        len_q;
  logic signed [afe_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                             active_q, active_d;

  logic [afe_pkg::SMP_W-1:0]        smp_q;
  logic [afe_pkg::ABS_W-1:0]        abs_q, abs_d;
  logic                             neg_q;
  logic [afe_pkg::MAG_W-1:0]        mag_q, mag_d;
  logic                             bypass_q, bypass_d;
  logic                             done_q, done_d;

  logic [afe_pkg::PROD_W-1:0]       prod_q;
  logic [afe_pkg::MAG_W-1:0]        rem_q, rem_d;
  logic [afe_pkg::QUO_W-1:0]        acc_q, acc_d;
  logic                             ovf_q;
  logic [afe_pkg::STEP_W-1:0]       step_q;

  logic [afe_pkg::LEN_W-1:0]        div;
  afe_pkg::req_e                    req;
  logic signed [afe_pkg::CNT_W-1:0] cnt_dec;
  logic signed [afe_pkg::CNT_W:0]   neg_div;

  logic [afe_pkg::MAG_W:0]          trial, diff;
  logic                             ge;
  logic [afe_pkg::SMP_W-1:0]        res;

  assign div     = (len_q == '0) ? afe_pkg::LEN_W'(1) : len_q;
  assign req     = afe_pkg::req_e'(in_word_i.req_type);
  assign cnt_dec = cnt_q - afe_pkg::CNT_W'(1);
  assign neg_div = -$signed({2'b00, div});

  assign status_o = '{
    has_result: (req == afe_pkg::REQ_SAMPLE) && active_q,
    div_last:   (step_q == afe_pkg::STEP_W'(afe_pkg::QUO_W - 1))
  };

  // fade counter update for the word being taken
  always_comb begin
    cnt_d    = cnt_q;
    active_d = active_q;
    mag_d    = '0;
    bypass_d = 1'b0;
    done_d   = 1'b0;
    abs_d    = in_word_i.sample_in[afe_pkg::SMP_W-1]
             ? afe_pkg::ABS_W'(-$signed({in_word_i.sample_in[afe_pkg::SMP_W-1],
                                          in_word_i.sample_in}))
             : {1'b0, in_word_i.sample_in};
    case (req)
      afe_pkg::REQ_START: begin
        active_d = 1'b1;
        cnt_d    = -afe_pkg::CNT_W'(1);
      end
      afe_pkg::REQ_FADE_DOWN: begin
        if (active_q) begin
          if (cnt_q < 0)       cnt_d = -cnt_q;
          else if (cnt_q == 0) cnt_d = $signed({1'b0, div});
        end
      end
      afe_pkg::REQ_STOP: begin
        active_d = 1'b0;
        cnt_d    = '0;
      end
      afe_pkg::REQ_SAMPLE: begin
        if (cnt_q > 0) begin
          cnt_d = cnt_dec;
          mag_d = cnt_dec[afe_pkg::MAG_W-1:0];
          if (cnt_dec == 0) begin
            done_d   = 1'b1;
            active_d = 1'b0;
          end
        end else if (cnt_q < 0) begin
          mag_d = afe_pkg::MAG_W'(-cnt_dec);
          // fade-in ends at full level
          if ($signed({cnt_dec[afe_pkg::CNT_W-1], cnt_dec}) <= neg_div) cnt_d = '0;
          else                                                          cnt_d = cnt_dec;
        end else begin
          bypass_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // one quotient bit per step
  always_comb begin
    trial = {rem_q, acc_q[afe_pkg::QUO_W-1]};
    ge    = trial >= {1'b0, div};
    diff  = trial - {1'b0, div};
    rem_d = ge ? diff[afe_pkg::MAG_W-1:0] : trial[afe_pkg::MAG_W-1:0];
    acc_d = {acc_q[afe_pkg::QUO_W-2:0], ge};
  end

  // sign, saturate, or pass the sample at full level
  always_comb begin
    if (bypass_q) begin
      res = smp_q;
    end else if (neg_q) begin
      if (ovf_q || acc_q > afe_pkg::SAT_NEG_MAG) res = afe_pkg::SAT_NEG;
      else                                        res = afe_pkg::SMP_W'(-acc_q);
    end else begin
      if (ovf_q || acc_q > afe_pkg::SAT_POS_MAG) res = afe_pkg::SAT_POS;
      else                                        res = acc_q[afe_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= afe_pkg::LEN_RESET;
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else begin
      if (cfg_we_i) len_q <= cfg_wdata_i;
      if (cmd_i.take) begin
        cnt_q    <= cnt_d;
        active_q <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      smp_q    <= in_word_i.sample_in;
      abs_q    <= abs_d;
      neg_q    <= in_word_i.sample_in[afe_pkg::SMP_W-1];
      mag_q    <= mag_d;
      bypass_q <= bypass_d;
      done_q   <= done_d;
    end
    if (cmd_i.mul_en) prod_q <= afe_pkg::PROD_W'(abs_q) * afe_pkg::PROD_W'(mag_q);
    if (cmd_i.div_init) begin
      rem_q  <= prod_q[afe_pkg::PROD_W-1:afe_pkg::QUO_W];
      acc_q  <= prod_q[afe_pkg::QUO_W-1:0];
      ovf_q  <= prod_q[afe_pkg::PROD_W-1:afe_pkg::QUO_W] >= div;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      step_q <= step_q + afe_pkg::STEP_W'(1);
    end
    if (cmd_i.load_out) begin
      out_word_o.sample_out <= res;
      out_word_o.fade_done  <= done_q;
    end
  end

endmodule

// ===== rtl/core/audio_fade_envelope_unit.sv =====
// Top level of the audio fade envelope unit.
// Depends on afe_pkg, afe_ctrl and afe_datapath.

// Applies a linear fade to a stream of signed 16-bit samples. Command words
// (start, fade down, stop) and samples while the stream is stopped give no
// result. A sample word of an active stream passes, from acceptance to the
// next acceptance, through these steps: taking it and stepping the fade
// counter, the sample-by-gain multiply, loading the divider, the restoring
// divider that yields one quotient bit per cycle, and moving the result into
// the output register once that register is free. The output register holds a
// finished word while the next input word is accepted. The fade length
// register may be written at any time the unit is idle and takes effect on
// the next word.
module audio_fade_envelope_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [afe_pkg::LEN_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  afe_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output afe_pkg::out_word_t        out_word_o
);

  afe_pkg::ctrl_cmd_t  cmd;
  afe_pkg::dp_status_t status;

  afe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  afe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule
